### design/pcie_owt_pkg.sv
package pcie_owt_pkg;

    // Field widths
    localparam int ADDR_W     = 40;
    localparam int PCIE_W     = 64;
    localparam int MIB_W      = 20;
    localparam int MIB_SHIFT  = 20;
    localparam int IDX_W      = 2;
    localparam int WIN_SLOTS  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes: four range registers, then four PCIe base registers
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PCIE_BASE0 = 3'd4;

    // Range reset: base all ones, limit zero, so the window starts disabled
    localparam logic [ADDR_W-1:0] RANGE_RESET = 40'h00000fffff;

    // Decoded settings of one window
    typedef struct packed {
        logic              enable;
        logic [MIB_W-1:0]  base_mb;
        logic [MIB_W-1:0]  limit_mib;
        logic [PCIE_W-1:0] pcie_base;
    } win_cfg_t;

    // One translated word
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  window_index;
        logic [PCIE_W-1:0] pcie_address;
    } xlat_result_t;

endpackage

### design/pcie_owt_cfg.sv
module pcie_owt_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pcie_owt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcie_owt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output pcie_owt_pkg::win_cfg_t               win_cfg [pcie_owt_pkg::WIN_SLOTS]
);

    logic [pcie_owt_pkg::ADDR_W-1:0] range_reg     [pcie_owt_pkg::WIN_SLOTS];
    logic [pcie_owt_pkg::ADDR_W-1:0] range_next    [pcie_owt_pkg::WIN_SLOTS];
    logic [pcie_owt_pkg::PCIE_W-1:0] pcie_base_reg [pcie_owt_pkg::WIN_SLOTS];
    logic [pcie_owt_pkg::PCIE_W-1:0] pcie_base_next[pcie_owt_pkg::WIN_SLOTS];
    logic [1:0]                      slot;

    assign slot = cfg_index[1:0];

    // Decode the register write: upper half is PCIe bases, lower half ranges
    always_comb begin
        for (int w = 0; w < pcie_owt_pkg::WIN_SLOTS; w++) begin
            range_next[w]     = range_reg[w];
            pcie_base_next[w] = pcie_base_reg[w];
        end
        if (cfg_wr_en) begin
            if (cfg_index >= pcie_owt_pkg::CFG_PCIE_BASE0) begin
                pcie_base_next[slot] = cfg_wdata;
            end else begin
                range_next[slot] = cfg_wdata[pcie_owt_pkg::ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < pcie_owt_pkg::WIN_SLOTS; w++) begin
                range_reg[w]     <= pcie_owt_pkg::RANGE_RESET;
                pcie_base_reg[w] <= '0;
            end
        end else begin
            for (int w = 0; w < pcie_owt_pkg::WIN_SLOTS; w++) begin
                range_reg[w]     <= range_next[w];
                pcie_base_reg[w] <= pcie_base_next[w];
            end
        end
    end

    // Split fields and qualify each window: limit not below base, no PCIe wrap
    for (genvar w = 0; w < pcie_owt_pkg::WIN_SLOTS; w++) begin : g_win
        logic [pcie_owt_pkg::MIB_W-1:0]  base_mb;
        logic [pcie_owt_pkg::MIB_W-1:0]  limit_mib;
        logic [pcie_owt_pkg::MIB_W:0]    size_mb;
        logic [pcie_owt_pkg::PCIE_W:0]   end_sum;

        assign base_mb   = range_reg[w][pcie_owt_pkg::MIB_W-1:0];
        assign limit_mib = range_reg[w][pcie_owt_pkg::ADDR_W-1:pcie_owt_pkg::MIB_W];
        assign size_mb   = {1'b0, limit_mib} - {1'b0, base_mb} + 21'd1;
        assign end_sum   = {1'b0, pcie_base_reg[w]}
                         + {24'd0, size_mb, {pcie_owt_pkg::MIB_SHIFT{1'b0}}};

        assign win_cfg[w].enable    = (limit_mib >= base_mb) && !end_sum[pcie_owt_pkg::PCIE_W];
        assign win_cfg[w].base_mb   = base_mb;
        assign win_cfg[w].limit_mib = limit_mib;
        assign win_cfg[w].pcie_base = pcie_base_reg[w];
    end

endmodule

### design/pcie_owt_match.sv
module pcie_owt_match #(
    parameter int WINDOWS = 4
) (
    input  logic [pcie_owt_pkg::ADDR_W-1:0] cpu_address,
    input  pcie_owt_pkg::win_cfg_t          win_cfg [pcie_owt_pkg::WIN_SLOTS],
    output pcie_owt_pkg::xlat_result_t      result
);

    logic [pcie_owt_pkg::MIB_W-1:0]  addr_mb;
    logic [WINDOWS-1:0]              win_hit;
    logic [pcie_owt_pkg::PCIE_W-1:0] win_xlat [WINDOWS];

    assign addr_mb = cpu_address[pcie_owt_pkg::ADDR_W-1:pcie_owt_pkg::MIB_SHIFT];

    // Compare and translate in every window side by side
    for (genvar w = 0; w < WINDOWS; w++) begin : g_win
        logic [pcie_owt_pkg::ADDR_W-1:0] offset;

        assign offset = cpu_address
                      - {win_cfg[w].base_mb, {pcie_owt_pkg::MIB_SHIFT{1'b0}}};
        assign win_hit[w] = win_cfg[w].enable
                          && (addr_mb >= win_cfg[w].base_mb)
                          && (addr_mb <= win_cfg[w].limit_mib);
        assign win_xlat[w] = win_cfg[w].pcie_base + {24'd0, offset};
    end

    // Pick the highest-numbered hit; a miss gives all zeros
    always_comb begin
        result = '0;
        for (int w = 0; w < WINDOWS; w++) begin
            if (win_hit[w]) begin
                result.hit          = 1'b1;
                result.window_index = pcie_owt_pkg::IDX_W'(w);
                result.pcie_address = win_xlat[w];
            end
        end
    end

endmodule

### design/pcie_outbound_window_translate.sv
// Outbound address translation through up to four windows.
// The s_ channel carries one CPU byte address per word; the m_ channel returns
// one word per address: hit flag, winning window index and the 64-bit PCIe
// address (index and address are zero on a miss). Windows are set through the
// cfg_ write port: indexes 0..3 hold the MiB ranges, 4..7 the PCIe bases.
// Write registers only while no word is in flight.
// Each accepted word is taken into the input register; the match logic feeds
// the result register, which drives m_. Throughput: one word per cycle while
// the receiver does not stall; window compares and base plus offset adds all
// sit in the single logic stage between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; s_ready drops only when both are full.
// Reset clears both valid flags and returns every window to disabled
// (base above limit) with PCIe base zero.
module pcie_outbound_window_translate #(
    parameter int WINDOWS = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pcie_owt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcie_owt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [pcie_owt_pkg::ADDR_W-1:0]      s_cpu_address,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit,
    output logic [pcie_owt_pkg::IDX_W-1:0]       m_window_index,
    output logic [pcie_owt_pkg::PCIE_W-1:0]      m_pcie_address
);

    pcie_owt_pkg::win_cfg_t       win_cfg [pcie_owt_pkg::WIN_SLOTS];
    pcie_owt_pkg::xlat_result_t   xlat;
    pcie_owt_pkg::xlat_result_t   result_reg;
    pcie_owt_pkg::xlat_result_t   result_next;
    logic [pcie_owt_pkg::ADDR_W-1:0] addr_reg;
    logic [pcie_owt_pkg::ADDR_W-1:0] addr_next;
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         advance;

    pcie_owt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .win_cfg   (win_cfg)
    );

    pcie_owt_match #(
        .WINDOWS (WINDOWS)
    ) u_match (
        .cpu_address (addr_reg),
        .win_cfg     (win_cfg),
        .result      (xlat)
    );

    // Advance the input word when the result register is free or draining
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            addr_next     = s_cpu_address;
        end
        if (advance) begin
            out_valid_next = in_valid_reg;
            result_next    = xlat;
        end
    end

    // Hold payload; only valid flags need reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        result_reg <= result_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_hit          = result_reg.hit;
    assign m_window_index = result_reg.window_index;
    assign m_pcie_address = result_reg.pcie_address;

endmodule

### tb/pcie_outbound_window_translate_test.sv
`timescale 1ns / 1ps

module pcie_outbound_window_translate_test;

    import pcie_owt_pkg::*;

    localparam logic [MIB_W-1:0] MIB_MAX = '1;
    localparam int RANDOM_PHASES = 19;
    localparam int PHASE_WORDS   = 100;
    localparam int QUIET_PHASES  = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_cpu_address = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_hit;
    logic [IDX_W-1:0]      m_window_index;
    logic [PCIE_W-1:0]     m_pcie_address;

    // Shadow copy of the window registers
    logic [ADDR_W-1:0]     win_range [WIN_SLOTS];
    logic [PCIE_W-1:0]     win_pcie_base [WIN_SLOTS];

    // Raw register data for the next configuration pass
    logic [CFG_DATA_W-1:0] next_range [WIN_SLOTS];
    logic [CFG_DATA_W-1:0] next_base [WIN_SLOTS];

    xlat_result_t          pending_xlat [$];
    int                    error_count = 0;
    int                    stall_left = 0;
    bit                    idle_on = 1'b1;

    pcie_outbound_window_translate uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cpu_address  (s_cpu_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_window_index (m_window_index),
        .m_pcie_address (m_pcie_address)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Look the address up in every window; the highest enabled hit wins
    function automatic xlat_result_t predict_translation(input logic [ADDR_W-1:0] addr);
        xlat_result_t      r;
        logic [MIB_W-1:0]  base_mb;
        logic [MIB_W-1:0]  limit_mib;
        logic [MIB_W-1:0]  addr_mb;
        logic [PCIE_W-1:0] size;
        logic [PCIE_W:0]   reach;
        r = '0;
        addr_mb = addr[ADDR_W-1:MIB_SHIFT];
        for (int w = 0; w < WIN_SLOTS; w++) begin
            base_mb   = win_range[w][MIB_W-1:0];
            limit_mib = win_range[w][2*MIB_W-1:MIB_W];
            if (limit_mib >= base_mb) begin
                size  = (PCIE_W'(limit_mib) - PCIE_W'(base_mb) + 1) << MIB_SHIFT;
                reach = {1'b0, win_pcie_base[w]} + {1'b0, size};
                // Drop windows whose PCIe span runs past the top of the space
                if (!reach[PCIE_W] && addr_mb >= base_mb && addr_mb <= limit_mib) begin
                    r.hit          = 1'b1;
                    r.window_index = IDX_W'(w);
                    r.pcie_address = win_pcie_base[w]
                                   + (PCIE_W'(addr) - (PCIE_W'(base_mb) << MIB_SHIFT));
                end
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // Aim mostly at window interiors and edges, sometimes anywhere
    function automatic logic [ADDR_W-1:0] pick_address();
        int               w;
        logic [MIB_W-1:0] b;
        logic [MIB_W-1:0] l;
        w = $urandom_range(0, WIN_SLOTS - 1);
        b = win_range[w][MIB_W-1:0];
        l = win_range[w][2*MIB_W-1:MIB_W];
        if (l < b || $urandom_range(0, 7) == 0)
            return random_address();
        case ($urandom_range(0, 7))
            0: return ADDR_W'(b) << MIB_SHIFT;
            1: return (ADDR_W'(l) << MIB_SHIFT) | ADDR_W'(20'hfffff);
            2: return (ADDR_W'(b) << MIB_SHIFT) - 1;
            3: return ((ADDR_W'(l) << MIB_SHIFT) | ADDR_W'(20'hfffff)) + 1;
            default: return {MIB_W'($urandom_range(b, l)), MIB_W'($urandom)};
        endcase
    endfunction

    // Record a failure, print only the first ten
    function automatic void report_mismatch(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Write all eight registers back to back, updating the shadow copy after each
    task automatic write_windows();
        for (int i = 0; i < 2 * WIN_SLOTS; i++) begin
            cfg_wr_en <= 1'b1;
            if (i < WIN_SLOTS) begin
                cfg_index <= CFG_IDX_W'(CFG_RANGE0 + i);
                cfg_wdata <= next_range[i];
            end else begin
                cfg_index <= CFG_IDX_W'(CFG_PCIE_BASE0 + i - WIN_SLOTS);
                cfg_wdata <= next_base[i - WIN_SLOTS];
            end
            @(posedge aclk);
            if (i < WIN_SLOTS)
                win_range[i] = next_range[i][ADDR_W-1:0];
            else
                win_pcie_base[i - WIN_SLOTS] = next_base[i - WIN_SLOTS];
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one address word, with an optional idle burst ahead of it
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cpu_address <= addr;
        do @(posedge aclk); while (!s_ready);
        pending_xlat.push_back(predict_translation(addr));
    endtask

    // Stop sending and wait for every outstanding word to return
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_xlat.size() != 0) @(posedge aclk);
    endtask

    // Receiver side: random stall bursts while idle_on is set
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each returned word with the oldest prediction
    always @(posedge aclk) begin : check_result
        xlat_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_xlat.size() == 0) begin
                report_mismatch($sformatf("unexpected word hit=%0b index=%0d addr=%h",
                                          m_hit, m_window_index, m_pcie_address));
            end else begin
                want = pending_xlat.pop_front();
                if (m_hit !== want.hit || m_window_index !== want.window_index ||
                    m_pcie_address !== want.pcie_address)
                    report_mismatch($sformatf(
                        "expected hit=%0b index=%0d addr=%h, got hit=%0b index=%0d addr=%h",
                        want.hit, want.window_index, want.pcie_address,
                        m_hit, m_window_index, m_pcie_address));
            end
        end
    end

    // After reset every window is disabled, so everything misses
    task automatic test_reset_state();
        send_address('0);
        send_address('1);
        send_address(40'h00_fff0_0000);
        drain();
    endtask

    // Window boundaries, overlap priority, exact wrap and top-of-space results
    task automatic test_window_edges();
        logic [ADDR_W-1:0] probes [9] = '{
            40'h00_0000_0000, 40'hff_ffff_ffff, 40'h00_0100_0000,
            40'h00_017f_ffff, 40'h00_0180_0000, 40'h00_020f_ffff,
            40'h00_0210_0000, 40'h00_01f0_0000, 40'h00_00ff_ffff};
        next_range[0] = 64'h0000_00ff_fff0_0000;
        next_base[0]  = 64'h1000_0000_0000_0000;
        next_range[1] = 64'h0000_0000_01f0_0010;
        next_base[1]  = 64'h0000_0040_0000_0000;
        // Span ends exactly at the top of the PCIe space: disabled
        next_range[2] = 64'h0000_00ff_ffff_ffff;
        next_base[2]  = 64'hffff_ffff_fff0_0000;
        // Overlaps window 1 and reaches one byte short of the top
        next_range[3] = 64'h0000_0000_0200_0018;
        next_base[3]  = 64'hffff_ffff_ff6f_ffff;
        write_windows();
        foreach (probes[i]) send_address(probes[i]);
        drain();
    endtask

    // Limit below base, wrap past the top, single-MiB windows, masked upper bits
    task automatic test_disable_cases();
        logic [ADDR_W-1:0] probes [9] = '{
            40'h00_0050_0000, 40'h00_0040_0000, 40'h00_0000_0000,
            40'h00_000f_ffff, 40'h00_0010_0000, 40'hff_fff0_0000,
            40'hff_ffff_ffff, 40'h80_0000_0000, 40'hff_ffef_ffff};
        next_range[0] = 64'h0000_0000_0040_0005;
        next_base[0]  = 64'h1234_5678_9abc_def0;
        next_range[1] = 64'hffff_ff00_0000_0000;
        next_base[1]  = 64'hffff_ffff_ffef_ffff;
        next_range[2] = 64'h0000_00ff_ffff_ffff;
        next_base[2]  = 64'h0000_0000_0000_0000;
        next_range[3] = 64'h0000_00ff_fff0_0000;
        next_base[3]  = 64'hffff_ff00_0000_0001;
        write_windows();
        foreach (probes[i]) send_address(probes[i]);
        drain();
    endtask

    // Draw a fresh set of windows, leaning on the interesting shapes
    task automatic randomize_windows();
        logic [MIB_W-1:0]  b;
        logic [MIB_W-1:0]  l;
        logic [PCIE_W-1:0] size;
        for (int w = 0; w < WIN_SLOTS; w++) begin
            b = MIB_W'($urandom);
            case ($urandom_range(0, 5))
                0: l = MIB_W'($urandom);
                1, 2: l = (b > MIB_MAX - 64) ? MIB_MAX : MIB_W'(b + $urandom_range(0, 63));
                3: begin
                    b = MIB_W'($urandom_range(0, 15));
                    l = MIB_MAX - MIB_W'($urandom_range(0, 15));
                end
                4: begin
                    if (b == 0) b = 1;
                    l = MIB_W'($urandom_range(0, b - 1));
                end
                default: begin
                    b = $urandom_range(0, 1) ? '0 : MIB_MAX;
                    l = (b == 0) ? MIB_W'($urandom) : MIB_MAX;
                end
            endcase
            next_range[w] = {$urandom, $urandom};
            next_range[w][ADDR_W-1:0] = {l, b};
            next_base[w] = {$urandom, $urandom};
            // Park the PCIe span just below, at, or just past the top
            if (l >= b && $urandom_range(0, 3) == 0) begin
                size = (PCIE_W'(l) - PCIE_W'(b) + 1) << MIB_SHIFT;
                next_base[w] = ~size + PCIE_W'($urandom_range(0, 2));
            end
        end
    endtask

    task automatic test_random_windows();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = (p < RANDOM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            randomize_windows();
            write_windows();
            for (int n = 0; n < PHASE_WORDS; n++) send_address(pick_address());
            drain();
        end
    endtask

    initial begin
        for (int w = 0; w < WIN_SLOTS; w++) begin
            win_range[w]     = RANGE_RESET;
            win_pcie_base[w] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_window_edges();
        test_disable_cases();
        test_random_windows();
        drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_xlat.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### pcie_outbound_window_translate.f
design/pcie_owt_pkg.sv
design/pcie_owt_cfg.sv
design/pcie_owt_match.sv
design/pcie_outbound_window_translate.sv
tb/pcie_outbound_window_translate_test.sv
